[rtl/hdv_pkg.sv]
package hdv_pkg;

  localparam int BIN_W = 17;
  localparam logic [BIN_W-1:0] BIN_SAT = {BIN_W{1'b1}};

  localparam int PIX_W = 11;
  localparam int DIM_W = 9;
  localparam int DV_W  = 8;
  localparam int ST_W  = 2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [ST_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [ST_W-1:0] STATUS_SIZE_ERR = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FMT_ERR  = 2'd2;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

[rtl/hdv_bin_ram.sv]
module hdv_bin_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [hdv_pkg::BIN_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [hdv_pkg::BIN_W-1:0]  rd_data
);

  logic [hdv_pkg::BIN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the contents before a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/hdv_mode_scan.sv]
module hdv_mode_scan #(
  parameter int AW = 8
) (
  input  logic                       clk,
  input  hdv_pkg::scan_ctl_t         ctl,
  input  logic [AW-1:0]              idx,
  input  logic [hdv_pkg::BIN_W-1:0]  rd_data,
  output logic [AW-1:0]              best_val,
  output logic [hdv_pkg::BIN_W-1:0]  best_cnt
);

  // strict greater keeps the smallest value on ties
  always_ff @(posedge clk) begin
    if (ctl.valid && (ctl.first || (rd_data > best_cnt))) begin
      best_val <= idx;
      best_cnt <= rd_data;
    end
  end

endmodule

[rtl/histogram_dominant_value_top.sv]
// Histogram mode finder. Pixels stream in at one per cycle (under a size error,
// only while the output register is free); each in-range value (0 to MAX_VALUE)
// bumps a saturating 17-bit bin in a one-read, one-write bin memory through a
// read-modify-write pipeline with one stage of forwarding, so repeated values
// back to back cost nothing. After image_rows * image_cols pixels, intake stops:
// a drain state retires the last update, then a sweep reads every bin once
// through the single read port while writing it back to zero, then the result
// is loaded into the output register. Out of reset the same sweep clears the
// memory, so no pixel is taken until it ends. With a size error every pixel is
// answered from the output register at once and the frame state is left alone.
// Configuration is accepted every cycle and must only change between frames.
module histogram_dominant_value_top #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int MAX_VALUE = 255
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [hdv_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hdv_pkg::PIX_W-1:0]  pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hdv_pkg::ST_W-1:0]          status,
  output logic [hdv_pkg::DV_W-1:0]          dominant_value,
  output logic [hdv_pkg::BIN_W-1:0]         occurrences
);

  localparam int NBINS = MAX_VALUE + 1;
  localparam int AW    = (NBINS > 2) ? $clog2(NBINS) : 1;
  localparam int CW    = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int FW    = 2 * hdv_pkg::DIM_W;
  localparam int CMPW  = ((CW > FW) ? CW : FW) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VALUE);

  hdv_pkg::state_t state, state_next;

  logic [hdv_pkg::DIM_W-1:0] image_rows, image_cols;
  logic [CW-1:0]             pix_cnt;
  logic                      fmt_err;
  logic                      emit;

  logic [AW-1:0]             scan_addr;
  logic                      scan_rd;
  logic [AW-1:0]             scan_rd_idx;

  logic                      s1_valid;
  logic [AW-1:0]             s1_addr;
  logic                      fw_valid;
  logic [AW-1:0]             fw_addr;
  logic [hdv_pkg::BIN_W-1:0] fw_data;

  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [hdv_pkg::BIN_W-1:0] wr_data, rd_data, cur_bin;

  logic [AW-1:0]             best_val;
  logic [hdv_pkg::BIN_W-1:0] best_cnt;
  hdv_pkg::scan_ctl_t        scan_ctl;

  logic [FW-1:0]             frame_len;
  logic                      size_err, in_range, last_pix, accept;
  logic                      scan_done, fin_go, load_size, load_fin, out_free;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= '0;
      image_cols <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hdv_pkg::CFG_ROWS: image_rows <= cfg_data;
        hdv_pkg::CFG_COLS: image_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign size_err = (image_rows == '0) || (32'(image_rows) > MAX_ROWS) ||
                    (image_cols == '0) || (32'(image_cols) > MAX_COLS);
  assign frame_len = FW'(image_rows) * FW'(image_cols);
  assign in_range  = !pixel_value[hdv_pkg::PIX_W-1] &&
                     (pixel_value[hdv_pkg::PIX_W-2:0] <= (hdv_pkg::PIX_W-1)'(MAX_VALUE));
  assign last_pix  = (CMPW'(pix_cnt) + CMPW'(1)) >= CMPW'(frame_len);

  assign out_free  = !out_valid || out_ready;
  assign scan_done = (scan_addr == LAST_ADDR);
  assign fin_go    = !scan_rd && (!emit || out_free);

  // FSM
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_size  = 1'b0;
    load_fin   = 1'b0;
    unique case (state)
      hdv_pkg::ST_RUN: begin
        in_ready = size_err ? out_free : 1'b1;
        if (in_valid && in_ready) begin
          if (size_err) begin
            load_size = 1'b1;
          end else if (last_pix) begin
            state_next = hdv_pkg::ST_DRAIN;
          end
        end
      end
      hdv_pkg::ST_DRAIN: begin
        state_next = hdv_pkg::ST_SCAN;
      end
      hdv_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = hdv_pkg::ST_FINISH;
        end
      end
      hdv_pkg::ST_FINISH: begin
        if (fin_go) begin
          load_fin   = emit;
          state_next = hdv_pkg::ST_RUN;
        end
      end
      default: state_next = hdv_pkg::ST_SCAN;
    endcase
  end

  assign accept = in_valid && in_ready && !size_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hdv_pkg::ST_SCAN;
    end else begin
      state <= state_next;
    end
  end

  // frame bookkeeping and sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt   <= '0;
      fmt_err   <= 1'b0;
      emit      <= 1'b0;
      scan_addr <= '0;
      scan_rd   <= 1'b0;
    end else begin
      scan_rd <= (state == hdv_pkg::ST_SCAN);
      if (accept) begin
        pix_cnt <= pix_cnt + CW'(1);
        if (!in_range) begin
          fmt_err <= 1'b1;
        end
      end
      if (state == hdv_pkg::ST_DRAIN) begin
        emit <= 1'b1;
      end
      if (state == hdv_pkg::ST_SCAN) begin
        scan_addr <= scan_done ? '0 : scan_addr + AW'(1);
      end
      if ((state == hdv_pkg::ST_FINISH) && fin_go) begin
        pix_cnt <= '0;
        fmt_err <= 1'b0;
        emit    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_rd_idx <= scan_addr;
  end

  // read-modify-write pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      s1_valid <= accept && in_range;
      fw_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= pixel_value[AW-1:0];
    fw_addr <= wr_addr;
    fw_data <= wr_data;
  end

  // forward the write that landed at the same edge as this read
  assign cur_bin = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rd_data;

  always_comb begin
    if (state == hdv_pkg::ST_SCAN) begin
      wr_en   = 1'b1;
      wr_addr = scan_addr;
      wr_data = '0;
      rd_en   = 1'b1;
      rd_addr = scan_addr;
    end else begin
      wr_en   = s1_valid;
      wr_addr = s1_addr;
      wr_data = (cur_bin == hdv_pkg::BIN_SAT) ? cur_bin : cur_bin + hdv_pkg::BIN_W'(1);
      rd_en   = accept;
      rd_addr = pixel_value[AW-1:0];
    end
  end

  hdv_bin_ram #(
    .DEPTH (NBINS),
    .AW    (AW)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign scan_ctl.valid = scan_rd;
  assign scan_ctl.first = (scan_rd_idx == '0);

  hdv_mode_scan #(
    .AW (AW)
  ) u_mode_scan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .idx      (scan_rd_idx),
    .rd_data  (rd_data),
    .best_val (best_val),
    .best_cnt (best_cnt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_size || load_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_size) begin
      status         <= hdv_pkg::STATUS_SIZE_ERR;
      dominant_value <= '0;
      occurrences    <= '0;
    end else if (load_fin) begin
      if (fmt_err) begin
        status         <= hdv_pkg::STATUS_FMT_ERR;
        dominant_value <= '0;
        occurrences    <= '0;
      end else begin
        status         <= hdv_pkg::STATUS_OK;
        dominant_value <= hdv_pkg::DV_W'(best_val);
        occurrences    <= best_cnt;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_intake_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == hdv_pkg::ST_SCAN) |-> !in_ready)
    else $error("pixel intake during bin sweep");

  a_pipe_empty_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == hdv_pkg::ST_SCAN) |-> !s1_valid)
    else $error("bin update pending during sweep");

  a_last_pixel_drains: assert property (@(posedge clk) disable iff (rst)
    (accept && last_pix) |=> (state == hdv_pkg::ST_DRAIN))
    else $error("frame end not followed by drain");

  a_no_load_clash: assert property (@(posedge clk) disable iff (rst)
    !(load_size && load_fin))
    else $error("two results loaded at once");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == hdv_pkg::STATUS_OK || status == hdv_pkg::STATUS_SIZE_ERR ||
                   status == hdv_pkg::STATUS_FMT_ERR))
    else $error("bad status code");
`endif

endmodule

[dv/histogram_dominant_value_top_tb.sv]
module histogram_dominant_value_top_tb;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int MAX_VALUE  = 255;
  localparam int NBINS      = MAX_VALUE + 1;
  localparam int PAUSE      = MAX_VALUE + 45;
  localparam int STUCK_MAX  = 4000;
  localparam int RAND_ITEMS = 650;
  localparam int QUIET_TAIL = 560;

  localparam int PIX_W = hdv_pkg::PIX_W;
  localparam int DIM_W = hdv_pkg::DIM_W;
  localparam int DV_W  = hdv_pkg::DV_W;
  localparam int ST_W  = hdv_pkg::ST_W;
  localparam int BIN_W = hdv_pkg::BIN_W;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [DV_W-1:0]  dominant;
    logic [BIN_W-1:0] count;
  } mode_result_t;

  class mode_scoreboard;
    logic [BIN_W-1:0] hist [NBINS];
    int unsigned pixels_taken;
    bit fmt_seen;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    mode_result_t expected_q[$];
    int errors;

    function new();
      clear_frame();
      rows = '0;
      cols = '0;
      errors = 0;
    endfunction

    function void clear_frame();
      foreach (hist[i]) hist[i] = '0;
      pixels_taken = 0;
      fmt_seen = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [DIM_W-1:0] val);
      if (idx == hdv_pkg::CFG_ROWS) rows = val;
      else cols = val;
    endfunction

    function void note_pixel(logic signed [PIX_W-1:0] v);
      mode_result_t r;
      int sv;
      int unsigned frame_len;
      int best_v;
      logic [BIN_W-1:0] best_c;
      sv = v;
      if (rows == 0 || rows > MAX_ROWS || cols == 0 || cols > MAX_COLS) begin
        r.status = hdv_pkg::STATUS_SIZE_ERR;
        r.dominant = '0;
        r.count = '0;
        expected_q.push_back(r);
        return;
      end
      if (sv < 0 || sv > MAX_VALUE) begin
        fmt_seen = 1'b1;
      end else if (hist[sv] != hdv_pkg::BIN_SAT) begin
        hist[sv] = hist[sv] + 1'b1;
      end
      pixels_taken++;
      frame_len = rows * cols;
      if (pixels_taken < frame_len) return;
      if (fmt_seen) begin
        r.status = hdv_pkg::STATUS_FMT_ERR;
        r.dominant = '0;
        r.count = '0;
      end else begin
        // strict compare keeps the smallest value on ties
        best_v = 0;
        best_c = hist[0];
        for (int c = 1; c < NBINS; c++) begin
          if (hist[c] > best_c) begin
            best_c = hist[c];
            best_v = c;
          end
        end
        r.status = hdv_pkg::STATUS_OK;
        r.dominant = best_v[DV_W-1:0];
        r.count = best_c;
      end
      expected_q.push_back(r);
      clear_frame();
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic [DV_W-1:0] dv,
                               logic [BIN_W-1:0] occ);
      mode_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d dominant_value %0d occurrences %0d",
               st, dv, occ);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (dv !== e.dominant) begin
        $error("dominant_value: expected %0d, actual %0d", e.dominant, dv);
        errors++;
      end
      if (occ !== e.count) begin
        $error("occurrences: expected %0d, actual %0d", e.count, occ);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_index = hdv_pkg::CFG_ROWS;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [PIX_W-1:0]  pixel_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ST_W-1:0]          status;
  logic [DV_W-1:0]          dominant_value;
  logic [BIN_W-1:0]         occurrences;

  mode_scoreboard sb = new();
  bit idle_on = 1'b1;
  int pixels_sent = 0;
  int sink_hold = 0;
  int stuck = 0;

  always #10 clk = ~clk;

  histogram_dominant_value_top #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_VALUE(MAX_VALUE)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .dominant_value(dominant_value),
    .occurrences   (occurrences)
  );

  // note inputs before checking so a same-edge answer finds its expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_pixel(pixel_value);
      if (out_valid && out_ready) sb.check_result(status, dominant_value, occurrences);
    end
  end

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_hold <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else if (stuck + 1 >= STUCK_MAX) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic send_pixel(input logic signed [PIX_W-1:0] v);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= v;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic write_size(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    cfg_valid <= 1'b1;
    cfg_index <= hdv_pkg::CFG_ROWS;
    cfg_data <= rows;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= hdv_pkg::CFG_COLS;
    cfg_data <= cols;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // hold intake, let every result land, then give the bin sweep time to finish
  task automatic drain_and_pause();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PAUSE) @(posedge clk);
  endtask

  task automatic send_frame(input int len);
    int style;
    int bad_pos;
    int a, b, c;
    int v;
    style = $urandom_range(0, 19);
    bad_pos = $urandom_range(0, len - 1);
    a = $urandom_range(0, 255);
    b = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
    c = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      if (style < 2) begin
        v = a;
      end else if (style < 9) begin
        case ($urandom_range(0, 2))
          0: v = a;
          1: v = b;
          default: v = c;
        endcase
      end else if (style < 14) begin
        v = $urandom_range(0, 255);
      end else if (style < 18) begin
        v = $urandom_range(0, 255);
        if (i == bad_pos) begin
          if ($urandom_range(0, 1) == 0) v = 0 - int'($urandom_range(1, 1024));
          else v = $urandom_range(256, 1023);
        end
      end else begin
        v = $urandom_range(0, 2047);
      end
      send_pixel(v[PIX_W-1:0]);
    end
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                           input int frames);
    drain_and_pause();
    idle_on = (pixels_sent < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
    write_size(rows, cols);
    if (rows == 0 || rows > MAX_ROWS || cols == 0 || cols > MAX_COLS) begin
      repeat (frames) send_pixel(PIX_W'($urandom_range(0, 2047)));
    end else begin
      repeat (frames) send_frame(rows * cols);
    end
  endtask

  initial begin
    int pick;
    int r;
    int c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset sizes are zero, so the first pixel is a size error
    send_pixel(11'sd0);

    drain_and_pause();
    write_size(9'd0, 9'd5);
    send_pixel(-11'sd1024);
    send_pixel(11'sd1023);

    drain_and_pause();
    write_size(9'd5, 9'd0);
    send_pixel(-11'sd1);

    drain_and_pause();
    write_size(9'd257, 9'd1);
    send_pixel(11'sd0);

    drain_and_pause();
    write_size(9'd1, 9'd511);
    send_pixel(11'sd255);

    drain_and_pause();
    write_size(9'd1, 9'd1);
    send_pixel(11'sd0);
    send_pixel(11'sd255);

    drain_and_pause();
    write_size(9'd2, 9'd2);
    // tie between two values: smaller wins
    send_pixel(11'sd7);
    send_pixel(11'sd3);
    send_pixel(11'sd7);
    send_pixel(11'sd3);
    // negative pixel gives a format error
    send_pixel(11'sd5);
    send_pixel(-11'sd1);
    send_pixel(11'sd5);
    send_pixel(11'sd5);
    // above range gives a format error
    send_pixel(11'sd1023);
    send_pixel(11'sd256);
    send_pixel(11'sd0);
    send_pixel(11'sd0);
    send_pixel(11'sd255);
    send_pixel(11'sd0);
    send_pixel(11'sd255);
    send_pixel(11'sd0);

    while (pixels_sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: begin
          r = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
          run_phase(r[DIM_W-1:0], DIM_W'($urandom_range(0, 511)), $urandom_range(1, 6));
        end
        1: begin
          c = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
          run_phase(DIM_W'($urandom_range(1, 256)), c[DIM_W-1:0], $urandom_range(1, 6));
        end
        2: run_phase(9'd256, 9'd1, 1);
        3: run_phase(9'd1, 9'd256, 1);
        4: run_phase(DIM_W'($urandom_range(5, 12)), DIM_W'($urandom_range(5, 12)), 1);
        default: begin
          run_phase(DIM_W'($urandom_range(1, 4)), DIM_W'($urandom_range(1, 6)),
                    $urandom_range(1, 5));
        end
      endcase
    end

    drain_and_pause();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hdv_pkg.sv
rtl/hdv_bin_ram.sv
rtl/hdv_mode_scan.sv
rtl/histogram_dominant_value_top.sv
dv/histogram_dominant_value_top_tb.sv
